// ----- hdl/nkc_pkg.sv -----
`timescale 1ns / 1ps

package nkc_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_KERNEL_DEF = 7;
   localparam int COEF_BITS_DEF  = 16;
   localparam int HEIGHT_LIMIT   = 4096;
   localparam int PIX_MAX        = 255;
   localparam int ROW_BITS       = $clog2(HEIGHT_LIMIT);
   localparam int CSR_ABITS      = 4;

   localparam logic [10:0] WIDTH_RESET  = 11'd512;
   localparam logic [12:0] HEIGHT_RESET = 13'd512;
   localparam logic [1:0]  RADIUS_RESET = 2'd1;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_DRAIN = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_RADIUS = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TAPS,
      S_FLUSH,
      S_DSTART,
      S_DIV,
      S_BORDER,
      S_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctrl_type;

endpackage

// ----- hdl/nkc_line_buf.sv -----
`timescale 1ns / 1ps

module nkc_line_buf
   import nkc_pkg::*;
#(
   parameter int DEPTH = MAX_KERNEL_DEF * MAX_WIDTH_DEF,
   parameter int ABITS = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [ABITS-1:0] wr_addr,
   input  logic [23:0]      wr_data,
   input  logic             rd_en,
   input  logic [ABITS-1:0] rd_addr,
   output logic [23:0]      rd_data
);

   logic [23:0] mem [DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/nkc_kernel_mem.sv -----
`timescale 1ns / 1ps

module nkc_kernel_mem
   import nkc_pkg::*;
#(
   parameter int SLOTS     = MAX_KERNEL_DEF * MAX_KERNEL_DEF,
   parameter int COEF_BITS = COEF_BITS_DEF,
   parameter int ABITS     = $clog2(SLOTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [ABITS-1:0]     wr_addr,
   input  logic [COEF_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ABITS-1:0]     rd_addr,
   output logic [COEF_BITS-1:0] rd_data
);

   logic [COEF_BITS-1:0] mem [SLOTS];
   logic [SLOTS-1:0]     valid_ff;
   logic [COEF_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- hdl/nkc_divider.sv -----
`timescale 1ns / 1ps

module nkc_divider
   import nkc_pkg::*;
#(
   parameter int ACC_BITS = 40,
   parameter int WS_BITS  = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2:0][ACC_BITS-1:0] acc,
   input  logic [WS_BITS-1:0]     wsum,
   output logic                   busy,
   output logic [2:0][7:0]        quot
);

   logic [2:0][ACC_BITS-1:0] rem_ff;
   logic [2:0][8:0]          quo_ff;
   logic [2:0]               pos_ff;
   logic [ACC_BITS-1:0]      dvs_ff;
   logic                     dz_ff;
   logic [3:0]               step_ff;
   logic                     busy_ff;
   logic [ACC_BITS-1:0]      trial;
   logic [ACC_BITS-1:0]      wsum_ext;

   assign wsum_ext = ACC_BITS'($signed(wsum));
   assign trial    = dvs_ff << step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && step_ff == 4'd0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvs_ff  <= wsum[WS_BITS-1] ? -wsum_ext : wsum_ext;
         dz_ff   <= (wsum == '0);
         step_ff <= 4'd8;
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= acc[i][ACC_BITS-1] ? -acc[i] : acc[i];
            pos_ff[i] <= (acc[i][ACC_BITS-1] == wsum[WS_BITS-1]);
            quo_ff[i] <= '0;
         end
      end else if (busy_ff) begin
         step_ff <= step_ff - 4'd1;
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[i] >= trial) begin
               rem_ff[i] <= rem_ff[i] - trial;
               quo_ff[i] <= {quo_ff[i][7:0], 1'b1};
            end else begin
               quo_ff[i] <= {quo_ff[i][7:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!pos_ff[i] || dz_ff) begin
            quot[i] = 8'd0;
         end else if (quo_ff[i][8]) begin
            quot[i] = 8'(PIX_MAX);
         end else begin
            quot[i] = quo_ff[i][7:0];
         end
      end
   end

   assign busy = busy_ff;

endmodule

// ----- hdl/normalized_kernel_convolution.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// req       req_valid / req_stall     command, coef_index, coef_value, blue/green/red_in
// rsp       rsp_valid / rsp_stall     blue/green/red_out, last_pixel
// csr       psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// An interior pixel stalls the input after it is accepted, through these steps: one line
// store read per kernel tap, a flush state, a divider start state, the nine divide steps and
// their completion, and a state that loads the result register once the output can take it.
// A border pixel stalls the input for a line read and the result load; others cause no stall.
// Reset clears positions and kernel valid bits and resets configuration; line store is kept.
// A result held by rsp_stall keeps the next one in the output stage, with the input stalled.

module normalized_kernel_convolution
   import nkc_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_KERNEL = MAX_KERNEL_DEF,
   parameter int COEF_BITS  = COEF_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic [5:0]           req_coef_index,
   input  logic signed [15:0]   req_coef_value,
   input  logic [7:0]           req_blue_in,
   input  logic [7:0]           req_green_in,
   input  logic [7:0]           req_red_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_blue_out,
   output logic [7:0]           rsp_green_out,
   output logic [7:0]           rsp_red_out,
   output logic                 rsp_last_pixel,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_ABITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int RMOD_BITS  = $clog2(MAX_KERNEL);
   localparam int TAP_BITS   = RMOD_BITS;
   localparam int LINE_DEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam int LINE_ABITS = $clog2(LINE_DEPTH);
   localparam int KSLOTS     = MAX_KERNEL * MAX_KERNEL;
   localparam int KABITS     = $clog2(KSLOTS);
   localparam int SUM_GROW   = $clog2(KSLOTS);
   localparam int ACC_BITS   = COEF_BITS + 9 + SUM_GROW;
   localparam int WS_BITS    = COEF_BITS + SUM_GROW;
   localparam int R_LIM      = (MAX_KERNEL - 1) / 2;
   localparam int VBITS      = RMOD_BITS + 2;
   localparam int DLY_BITS   = $clog2(4 * MAX_WIDTH);

   state_type state_ff, state_in;

   logic [10:0]          width_ff;
   logic [12:0]          height_ff;
   logic [1:0]           radius_ff;
   logic                 csr_wr;

   logic [COL_BITS-1:0]  last_col;
   logic [ROW_BITS-1:0]  last_row;
   logic [1:0]           eff_r;

   logic [COL_BITS-1:0]  in_col_ff;
   logic [ROW_BITS-1:0]  in_row_ff;
   logic [RMOD_BITS-1:0] in_rmod_ff;
   logic [DLY_BITS-1:0]  in_cnt_ff;
   logic [COL_BITS-1:0]  out_col_ff;
   logic [ROW_BITS-1:0]  out_row_ff;
   logic [RMOD_BITS-1:0] out_rmod_ff;
   logic                 full_ff;

   logic [TAP_BITS-1:0]  tap_k_ff, tap_l_ff;
   logic [TAP_BITS-1:0]  diam_m1;
   logic                 tap_vld_ff;
   logic                 interior_ff;
   logic                 interior;

   logic                 req_acc;
   logic                 is_load, is_pixel, is_drain;
   logic                 produce;
   logic                 emit_go;
   logic                 out_load;
   logic                 rd_en;

   logic [VBITS-1:0]     row_sum;
   logic [RMOD_BITS-1:0] row_slot;
   logic [COL_BITS-1:0]  tap_col;
   logic [LINE_ABITS-1:0] line_raddr, line_waddr;
   logic [KABITS-1:0]    kern_raddr;
   logic [23:0]          line_rdata;
   logic [COEF_BITS-1:0] coef;
   logic [31:0]          coef_ext;

   logic [2:0][ACC_BITS-1:0] acc_ff;
   logic [WS_BITS-1:0]       wsum_ff;
   logic [2:0][7:0]          quot;
   div_ctrl_type             div_ctrl;

   logic                 rsp_valid_ff;
   logic [7:0]           blue_ff, green_ff, red_ff;
   logic                 last_ff;

   // Configuration port.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr) begin
         case (reg_index_type'(paddr[3:2]))
            REG_WIDTH:  width_ff  <= pwdata[10:0];
            REG_HEIGHT: height_ff <= pwdata[12:0];
            REG_RADIUS: radius_ff <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[3:2]))
         REG_WIDTH:  prdata = {21'd0, width_ff};
         REG_HEIGHT: prdata = {19'd0, height_ff};
         REG_RADIUS: prdata = {30'd0, radius_ff};
         default:    prdata = 32'd0;
      endcase
   end

   logic restart;
   assign restart = csr_wr && (paddr[3:2] <= 2'(REG_RADIUS));

   // Effective frame geometry.
   always_comb begin
      if (width_ff == 11'd0) begin
         last_col = '0;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         last_col = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_BITS'(32'(width_ff) - 32'd1);
      end
      if (height_ff == 13'd0) begin
         last_row = '0;
      end else if (32'(height_ff) > HEIGHT_LIMIT) begin
         last_row = ROW_BITS'(HEIGHT_LIMIT - 1);
      end else begin
         last_row = ROW_BITS'(32'(height_ff) - 32'd1);
      end
      eff_r = (32'(radius_ff) > R_LIM) ? 2'(R_LIM) : radius_ff;
   end

   assign diam_m1 = TAP_BITS'({eff_r, 1'b0});

   assign interior = (32'(out_row_ff) >= 32'(eff_r)) &&
                     (32'(out_row_ff) + 32'(eff_r) <= 32'(last_row)) &&
                     (32'(out_col_ff) >= 32'(eff_r)) &&
                     (32'(out_col_ff) + 32'(eff_r) <= 32'(last_col));

   // Input decode.
   assign req_acc  = req_valid && !req_stall;
   assign is_load  = req_acc && (req_command == CMD_LOAD);
   assign is_pixel = req_acc && (req_command == CMD_PIXEL) && !full_ff;
   assign is_drain = req_acc && (req_command == CMD_DRAIN) && full_ff;
   assign produce  = 32'(in_cnt_ff) >=
                     32'(eff_r) * (32'(last_col) + 32'd1) + 32'(eff_r);
   assign emit_go  = (is_pixel && produce) || is_drain;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (emit_go) begin
               state_in = interior ? S_TAPS : S_BORDER;
            end
         end
         S_TAPS: begin
            if (tap_k_ff == diam_m1 && tap_l_ff == diam_m1) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH:  state_in = S_DSTART;
         S_DSTART: state_in = S_DIV;
         S_DIV: begin
            if (!div_ctrl.busy) begin
               state_in = S_OUT;
            end
         end
         S_BORDER: state_in = S_OUT;
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = (state_ff != S_IDLE);
      rd_en          = (state_ff == S_TAPS) || (state_ff == S_BORDER);
      div_ctrl.start = (state_ff == S_DSTART);
      out_load       = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Frame positions.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_rmod_ff  <= '0;
         in_cnt_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_rmod_ff <= '0;
         full_ff     <= 1'b0;
      end else begin
         if (is_pixel) begin
            if (in_col_ff == last_col && in_row_ff == last_row) begin
               in_cnt_ff <= '0;
            end else if (in_cnt_ff != '1) begin
               in_cnt_ff <= in_cnt_ff + 1'b1;
            end
            if (in_col_ff == last_col) begin
               in_col_ff <= '0;
               if (in_row_ff == last_row) begin
                  in_row_ff  <= '0;
                  in_rmod_ff <= '0;
                  full_ff    <= 1'b1;
               end else begin
                  in_row_ff  <= in_row_ff + 1'b1;
                  in_rmod_ff <= (32'(in_rmod_ff) == MAX_KERNEL - 1) ? '0 :
                                in_rmod_ff + 1'b1;
               end
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end
         if (out_load) begin
            if (out_col_ff == last_col) begin
               out_col_ff <= '0;
               if (out_row_ff == last_row) begin
                  out_row_ff  <= '0;
                  out_rmod_ff <= '0;
                  full_ff     <= 1'b0;
               end else begin
                  out_row_ff  <= out_row_ff + 1'b1;
                  out_rmod_ff <= (32'(out_rmod_ff) == MAX_KERNEL - 1) ? '0 :
                                 out_rmod_ff + 1'b1;
               end
            end else begin
               out_col_ff <= out_col_ff + 1'b1;
            end
         end
      end
   end

   // Tap walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff <= 1'b0;
      end else begin
         tap_vld_ff <= (state_ff == S_TAPS);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         tap_k_ff    <= '0;
         tap_l_ff    <= '0;
         interior_ff <= interior;
      end else if (state_ff == S_TAPS) begin
         if (tap_l_ff == diam_m1) begin
            tap_l_ff <= '0;
            tap_k_ff <= tap_k_ff + 1'b1;
         end else begin
            tap_l_ff <= tap_l_ff + 1'b1;
         end
      end
   end

   always_comb begin
      row_sum = VBITS'(out_rmod_ff) + VBITS'(MAX_KERNEL) + VBITS'(tap_k_ff) - VBITS'(eff_r);
      if (32'(row_sum) >= 2 * MAX_KERNEL) begin
         row_sum = row_sum - VBITS'(2 * MAX_KERNEL);
      end else if (32'(row_sum) >= MAX_KERNEL) begin
         row_sum = row_sum - VBITS'(MAX_KERNEL);
      end
      if (interior_ff) begin
         row_slot = row_sum[RMOD_BITS-1:0];
         tap_col  = out_col_ff + COL_BITS'(tap_l_ff) - COL_BITS'(eff_r);
      end else begin
         row_slot = out_rmod_ff;
         tap_col  = out_col_ff;
      end
      line_raddr = LINE_ABITS'(32'(row_slot) * MAX_WIDTH + 32'(tap_col));
      line_waddr = LINE_ABITS'(32'(in_rmod_ff) * MAX_WIDTH + 32'(in_col_ff));
      kern_raddr = KABITS'(32'(tap_k_ff) * MAX_KERNEL + 32'(tap_l_ff));
   end

   assign coef_ext = 32'(req_coef_value);

   nkc_line_buf #(
      .DEPTH (LINE_DEPTH),
      .ABITS (LINE_ABITS)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (is_pixel),
      .wr_addr (line_waddr),
      .wr_data ({req_red_in, req_green_in, req_blue_in}),
      .rd_en   (rd_en),
      .rd_addr (line_raddr),
      .rd_data (line_rdata)
   );

   nkc_kernel_mem #(
      .SLOTS     (KSLOTS),
      .COEF_BITS (COEF_BITS),
      .ABITS     (KABITS)
   ) u_kernel_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (is_load && (32'(req_coef_index) < KSLOTS)),
      .wr_addr (KABITS'(req_coef_index)),
      .wr_data (coef_ext[COEF_BITS-1:0]),
      .rd_en   (state_ff == S_TAPS),
      .rd_addr (kern_raddr),
      .rd_data (coef)
   );

   // Multiply-accumulate, one tap per cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         acc_ff  <= '0;
         wsum_ff <= '0;
      end else if (tap_vld_ff) begin
         wsum_ff <= wsum_ff + WS_BITS'($signed(coef));
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= acc_ff[i] +
               ACC_BITS'($signed(coef) * $signed({1'b0, line_rdata[8*i +: 8]}));
         end
      end
   end

   nkc_divider #(
      .ACC_BITS (ACC_BITS),
      .WS_BITS  (WS_BITS)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_ctrl.start),
      .acc   (acc_ff),
      .wsum  (wsum_ff),
      .busy  (div_ctrl.busy),
      .quot  (quot)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (interior_ff) begin
            blue_ff  <= quot[0];
            green_ff <= quot[1];
            red_ff   <= quot[2];
         end else begin
            blue_ff  <= line_rdata[7:0];
            green_ff <= line_rdata[15:8];
            red_ff   <= line_rdata[23:16];
         end
         last_ff <= (out_col_ff == last_col) && (out_row_ff == last_row);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blue_out   = blue_ff;
   assign rsp_green_out  = green_ff;
   assign rsp_red_out    = red_ff;
   assign rsp_last_pixel = last_ff;

endmodule
